@@ hdl/rsbk_pkg.sv @@
// Shared types for the descending record sorter: record layout,
// sequencer state codes and the control group of the compare-swap unit.
// No dependencies.
`default_nettype none

package rsbk_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 16;

    // One stored record: key in the upper half, tag in the lower half.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_FETCH = 7'b0000010,
        ST_GRAB  = 7'b0000100,
        ST_SCAN  = 7'b0001000,
        ST_PUT   = 7'b0010000,
        ST_ERD   = 7'b0100000,
        ST_EOUT  = 7'b1000000
    } t_state;

    // Control group from the sequencer to the compare-swap unit.
    typedef struct packed {
        logic load;   // capture the record read from the store as the held entry
        logic scan;   // compare the held entry against the record read
        logic self;   // the record read is the held entry's own slot
    } t_cmp_ctl;

endpackage

`default_nettype wire

@@ hdl/record_sort_by_key_descending_top.sv @@
// Descending record sorter, top level. Depends on rsbk_pkg, rsbk_ram, rsbk_cmp.
// Collects records on the slave stream and returns them sorted by key, highest first.
`default_nettype none

// The block takes records (16-bit score key, 16-bit tag) one beat per cycle
// while it is loading, storing up to MAX_RECORDS of them; further records of
// the set are discarded and every result beat of that set then carries the
// dropped flag in tuser. The beat with tlast set ends the set (its own record
// is stored or dropped first). The block then stops accepting input and runs
// an exchange pass over the n stored records with a single comparator and a
// record RAM with one write and one read port: for each outer position the
// entry is held in the compare unit and scanned against all n slots, one slot
// per cycle, and then put back into its own slot. Emission follows once the
// first record is read from the RAM, at up to one beat per cycle while the
// receiver is ready, the last sorted record marked with tlast. Input is
// accepted again in the cycle after the final result beat is taken. No
// clearing pass is needed after reset.

module record_sort_by_key_descending_top
    import rsbk_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave side: tdata = {record_tag[31:16], score[15:0]}, tlast = last.
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [15:0] score, [31:16] record_tag
    input  wire logic        i_s_tlast,
    // Master side: one beat per stored record in descending key order.
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [15:0] out_tag, [31:16] out_score
    output logic             o_m_tlast,   // out_last
    output logic             o_m_tuser    // dropped
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    // Sequencer and counters.
    t_state        r_state, n_state;
    logic [CW-1:0] r_fill,  n_fill;
    logic          r_ovf,   n_ovf;
    logic [AW-1:0] r_last_idx, n_last_idx;
    logic [AW-1:0] r_a, n_a;
    logic [AW-1:0] r_b, n_b;
    logic [AW-1:0] r_k, n_k;

    // Datapath wiring.
    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_full;
    logic [CW-1:0] w_fill_nx;
    logic [CW-1:0] w_fill_dec;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_rec          w_wdata;
    logic [AW-1:0] w_raddr;
    t_rec          w_rdata;
    t_rec          w_in_rec;
    t_cmp_ctl      w_ctl;
    logic          w_swap;
    t_rec          w_held;

    assign o_s_tready = (r_state == ST_LOAD);
    assign o_m_tvalid = (r_state == ST_EOUT);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = o_m_tvalid && i_m_tready;

    assign w_full     = (r_fill == CW'(MAX_RECORDS));
    assign w_fill_nx  = w_full ? r_fill : r_fill + CW'(1);
    assign w_fill_dec = w_fill_nx - CW'(1);

    assign w_in_rec.key = i_s_tdata[15:0];
    assign w_in_rec.tag = i_s_tdata[31:16];

    // Output beat comes straight from the registered RAM read; the read
    // address stays on the current slot while the beat is stalled.
    assign o_m_tdata = {w_rdata.key, w_rdata.tag};
    assign o_m_tlast = (r_k == r_last_idx);
    assign o_m_tuser = r_ovf;

    // Compare-swap control.
    always_comb begin
        w_ctl.load = (r_state == ST_GRAB);
        w_ctl.scan = (r_state == ST_SCAN);
        w_ctl.self = (r_b == r_a);
    end

    // RAM write port: loading, a swap during the scan, or putting back the
    // held entry at the end of an outer step.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_a;
        w_wdata = w_held;
        case (r_state)
            ST_LOAD: begin
                w_we    = w_in_acc && !w_full;
                w_waddr = r_fill[AW-1:0];
                w_wdata = w_in_rec;
            end
            ST_SCAN: begin
                w_we    = w_swap;
                w_waddr = r_b;
            end
            ST_PUT: begin
                w_we    = 1'b1;
            end
            default: begin
                w_we    = 1'b0;
            end
        endcase
    end

    // RAM read address: the read data is registered and shows up in the following cycle.
    always_comb begin
        case (r_state)
            ST_FETCH: w_raddr = r_a;
            ST_GRAB:  w_raddr = '0;
            ST_SCAN:  w_raddr = r_b + AW'(1);
            ST_ERD:   w_raddr = r_k;
            ST_EOUT:  w_raddr = w_out_acc ? r_k + AW'(1) : r_k;
            default:  w_raddr = '0;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_ovf      = r_ovf;
        n_last_idx = r_last_idx;
        n_a        = r_a;
        n_b        = r_b;
        n_k        = r_k;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    n_fill = w_fill_nx;
                    n_ovf  = r_ovf || w_full;
                    if (i_s_tlast) begin
                        n_last_idx = w_fill_dec[AW-1:0];
                        n_a        = '0;
                        n_state    = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_GRAB;
            end
            ST_GRAB: begin
                n_b     = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                n_b = r_b + AW'(1);
                if (r_b == r_last_idx) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (r_a == r_last_idx) begin
                    n_k     = '0;
                    n_state = ST_ERD;
                end else begin
                    n_a     = r_a + AW'(1);
                    n_state = ST_FETCH;
                end
            end
            ST_ERD: begin
                n_state = ST_EOUT;
            end
            ST_EOUT: begin
                if (w_out_acc) begin
                    if (r_k == r_last_idx) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_fill  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_idx <= n_last_idx;
        r_a        <= n_a;
        r_b        <= n_b;
        r_k        <= n_k;
    end

    rsbk_ram #(
        .DEPTH (MAX_RECORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rsbk_cmp u_cmp (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_rd   (w_rdata),
        .o_swap (w_swap),
        .o_held (w_held)
    );

    // The fill count never passes the store depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_RECORDS))
        else $error("fill count beyond capacity");

    // Taking the final beat of a set clears the set state and reopens input.
    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_tlast) |=> (r_fill == '0) && !r_ovf && o_s_tready)
        else $error("set state not cleared after final beat");

    // Sort writes stay within the occupied slots.
    a_sort_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && (r_state != ST_LOAD)) |-> (w_waddr <= r_last_idx))
        else $error("sort write outside the occupied slots");

    // The held entry never trades with its own stale slot.
    a_no_self_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_swap |-> (r_b != r_a))
        else $error("swap against own slot");

endmodule

`default_nettype wire

@@ hdl/rsbk_ram.sv @@
// Record store of the sorter: one write port, one read port with registered data.
// Depends on rsbk_pkg for the record type.
`default_nettype none

module rsbk_ram
    import rsbk_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_rec          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_rec               o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/rsbk_cmp.sv @@
// Shared compare-swap unit: holds the entry at the outer position and
// trades it against each record read from the store. Depends on rsbk_pkg.
`default_nettype none

module rsbk_cmp
    import rsbk_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_cmp_ctl i_ctl,
    input  wire t_rec     i_rd,
    output logic          o_swap,
    output t_rec          o_held
);

    t_rec r_held;

    // Equal keys never trade places, and the own slot is stale in the store
    // while its value lives here, so it is left out of the compare.
    assign o_swap = i_ctl.scan && !i_ctl.self && (r_held.key > i_rd.key);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load || o_swap) begin
            r_held <= i_rd;
        end
    end

    assign o_held = r_held;

endmodule

`default_nettype wire

@@ bench/record_sort_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the descending record sorter: watches both stream channels,
// predicts the sorted beats of each set and compares them field by field.
// Depends on rsbk_pkg for the record layout and field widths.

module record_sort_checker
    import rsbk_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [15:0] score, [31:16] record_tag
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,   // [15:0] out_tag, [31:16] out_score
    input  wire logic        i_m_tlast,
    input  wire logic        i_m_tuser,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] score;
        logic             last;
        logic             dropped;
    } t_sorted_beat;

    t_sorted_beat sorted_queue[$];
    t_rec         held_rec[MAX_RECORDS];
    int           held_count;
    logic         overflow_seen;
    int           beat_no;

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("%0t: result beat %0d: %s expected %h got %h",
                 $realtime, beat_no, field, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_sorted_beat want;
        t_rec         swap_rec;
        int           a;
        int           b;
        if (!i_rst_n) begin
            sorted_queue.delete();
            held_count    = 0;
            overflow_seen = 1'b0;
            beat_no       = 0;
        end else begin
            // Results first: a new set can never be answered in the same cycle.
            if (i_m_tvalid && i_m_tready) begin
                if (sorted_queue.size() == 0) begin
                    report_mismatch("beat with nothing pending, tag", '0, i_m_tdata[15:0]);
                end else begin
                    want = sorted_queue.pop_front();
                    if (i_m_tdata[15:0] !== want.tag)
                        report_mismatch("out_tag", want.tag, i_m_tdata[15:0]);
                    if (i_m_tdata[31:16] !== want.score)
                        report_mismatch("out_score", want.score, i_m_tdata[31:16]);
                    if (i_m_tlast !== want.last)
                        report_mismatch("out_last", 16'(want.last), 16'(i_m_tlast));
                    if (i_m_tuser !== want.dropped)
                        report_mismatch("dropped", 16'(want.dropped), 16'(i_m_tuser));
                end
                beat_no++;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (held_count < MAX_RECORDS) begin
                    held_rec[held_count].key = i_s_tdata[15:0];
                    held_rec[held_count].tag = i_s_tdata[31:16];
                    held_count++;
                end else begin
                    overflow_seen = 1'b1;
                end
                if (i_s_tlast) begin
                    // Full exchange pass: every slot against every slot,
                    // swapping whenever the outer key is strictly larger.
                    for (a = 0; a < held_count; a++)
                        for (b = 0; b < held_count; b++)
                            if (held_rec[a].key > held_rec[b].key) begin
                                swap_rec    = held_rec[a];
                                held_rec[a] = held_rec[b];
                                held_rec[b] = swap_rec;
                            end
                    for (a = 0; a < held_count; a++) begin
                        want.tag     = held_rec[a].tag;
                        want.score   = held_rec[a].key;
                        want.last    = (a == held_count - 1);
                        want.dropped = overflow_seen;
                        sorted_queue.push_back(want);
                    end
                    held_count    = 0;
                    overflow_seen = 1'b0;
                end
            end
        end
        o_pending = sorted_queue.size();
    end

endmodule

@@ bench/record_sort_by_key_descending_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the descending record sorter: clock, reset, record stimulus
// and the final verdict. Depends on the sorter RTL, rsbk_pkg and record_sort_checker.

module record_sort_by_key_descending_top_tb;

    localparam int MAX_RECORDS  = 64;
    // Roughly how many records the run sends in total.
    localparam int ITEM_TARGET  = 460;
    // Many times the slowest plausible run of the whole test, including the long hold.
    localparam int LIMIT_CYCLES = 600_000;
    // Length of the single long receiver hold-off, and the beat count that arms it.
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_BEAT = 150;

    // How the keys of a random set are spread.
    typedef enum int {KEYS_ANY, KEYS_FEW, KEYS_EDGE} t_key_spread;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic [31:0] s_tdata;    // [15:0] score, [31:16] record_tag
    logic        s_tlast;
    wire         s_tready;
    wire         m_tvalid;
    logic        m_tready;
    wire  [31:0] m_tdata;    // [15:0] out_tag, [31:16] out_score
    wire         m_tlast;    // out_last
    wire         m_tuser;    // dropped

    int          fail_count;
    int          pending;
    int          beats_out;
    int          items_sent;
    int          cycle_count;
    int          set_index;
    int          set_size;
    int          hold_left;
    bit          hold_used;
    // While set, neither side idles; this gives one long stretch at full rate.
    bit          steady;

    record_sort_by_key_descending_top #(
        .MAX_RECORDS(MAX_RECORDS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tlast (s_tlast),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast),
        .o_m_tuser (m_tuser)
    );

    record_sort_checker #(
        .MAX_RECORDS(MAX_RECORDS)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_m_tuser   (m_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Output beats taken so far; the receiver uses it to place its long hold.
    initial beats_out = 0;
    always @(posedge i_clk) begin
        if (m_tvalid && m_tready)
            beats_out++;
    end

    // Receiver: random back-pressure, none during the steady stretch, and once
    // a long hold in the middle of an emission. During that hold the sender
    // keeps its next record on the bus, so the block backs up to its input.
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_used && beats_out >= HOLD_AT_BEAT) begin
                m_tready  <= 1'b0;
                hold_left = HOLD_CYCLES - 1;
                hold_used = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 26);
            end
        end
    end

    // Run limit: a hung block ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one record, with random idle cycles in front of it, and holds it
    // on the bus until the block takes it. Inputs only change at the falling edge.
    task automatic send_record(input logic [15:0] score, input logic [15:0] tag,
                               input logic last);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, score};
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
    endtask

    // Sends one whole set of random records; only the final one carries last.
    task automatic send_set(input int size, input t_key_spread spread);
        int          k;
        logic [15:0] score;
        for (k = 0; k < size; k++) begin
            case (spread)
                KEYS_ANY: begin
                    score = 16'($urandom_range(0, 65535));
                end
                KEYS_FEW: begin
                    // Many equal keys, so the order of ties is exercised.
                    score = 16'($urandom_range(0, 3));
                end
                default: begin
                    score = $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 15))
                                                 : 16'($urandom_range(0, 15));
                end
            endcase
            send_record(score, 16'($urandom_range(0, 65535)), k == size - 1);
        end
    endtask

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        steady     = 1'b0;
        items_sent = 0;
        i_rst_n    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single-record sets at both ends of the key and tag range.
        send_record(16'h0000, 16'h0000, 1'b1);
        send_record(16'hFFFF, 16'hFFFF, 1'b1);
        // Extreme keys mixed together.
        send_record(16'hFFFF, 16'h0001, 1'b0);
        send_record(16'h0000, 16'h0002, 1'b0);
        send_record(16'h8000, 16'h0003, 1'b0);
        send_record(16'h0001, 16'h0004, 1'b0);
        send_record(16'h7FFF, 16'h0005, 1'b1);
        // Equal keys are never swapped with each other.
        send_record(16'h1234, 16'hA001, 1'b0);
        send_record(16'h1234, 16'hA002, 1'b0);
        send_record(16'h1234, 16'hA003, 1'b0);
        send_record(16'h5555, 16'hAAAA, 1'b0);
        send_record(16'h1234, 16'hA004, 1'b1);
        // Already ascending and already descending inputs.
        send_record(16'h0010, 16'h5A5A, 1'b0);
        send_record(16'h0020, 16'hA5A5, 1'b0);
        send_record(16'h0030, 16'hFF00, 1'b0);
        send_record(16'h0040, 16'h00FF, 1'b1);
        send_record(16'hC000, 16'h0F0F, 1'b0);
        send_record(16'h8000, 16'hF0F0, 1'b0);
        send_record(16'h4000, 16'h3C3C, 1'b1);
        // A pair of equal keys on their own.
        send_record(16'hBEEF, 16'h1111, 1'b0);
        send_record(16'hBEEF, 16'h2222, 1'b1);

        // Random sets, mostly short. One set fills the store exactly and one
        // overflows it with its final three records dropped; a few more big sets
        // come at random.
        set_index = 0;
        while (items_sent < ITEM_TARGET) begin
            steady = (set_index >= 12 && set_index < 20);
            if (set_index == 4)
                set_size = MAX_RECORDS;
            else if (set_index == 9)
                set_size = MAX_RECORDS + 3;
            else if ($urandom_range(99) < 5)
                set_size = $urandom_range(MAX_RECORDS - 1, MAX_RECORDS + 6);
            else if ($urandom_range(99) < 45)
                set_size = $urandom_range(1, 4);
            else
                set_size = $urandom_range(5, 16);
            send_set(set_size, t_key_spread'($urandom_range(0, 2)));
            set_index++;
        end
        steady = 1'b0;
        @(negedge i_clk);
        s_tvalid <= 1'b0;

        // Drain the expected beats, then watch a while for stray ones.
        while (pending != 0)
            @(negedge i_clk);
        repeat (32) @(negedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
